>>> hdl/sqmm_pkg.sv
// Shared constants, codes and controller/datapath interface types for the matrix multiplier.
`default_nettype none

package sqmm_pkg;

	localparam int MATRIX_SIZE = 8;
	localparam int STORE_DEPTH = 64;
	localparam int ADDR_W      = 6;
	localparam int VAL_W       = 16;
	localparam int PROD_W      = 2 * VAL_W;
	localparam int ACC_W       = 35;
	localparam int CMD_W       = 2;
	localparam int CNT_W       = (MATRIX_SIZE > 1) ? $clog2(MATRIX_SIZE) : 1;
	localparam int TOTAL       = (MATRIX_SIZE * MATRIX_SIZE > STORE_DEPTH) ?
	                             STORE_DEPTH : MATRIX_SIZE * MATRIX_SIZE;
	localparam int S_DATA_W    = 24;
	localparam int M_DATA_W    = 48;

	typedef enum logic [CMD_W-1:0] {
		CMD_LOAD_A = 2'd0,
		CMD_LOAD_B = 2'd1,
		CMD_START  = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_code_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic              wr_a;
		logic              wr_b;
		logic              issue;
		logic              first;
		logic [ADDR_W-1:0] a_addr;
		logic [ADDR_W-1:0] b_addr;
		logic              emit;
		logic [ADDR_W-1:0] index;
		logic              last;
	} dp_cmd_t;

	// Status from the datapath back to the controller.
	typedef struct packed {
		logic busy;
		logic out_free;
	} dp_sts_t;

endpackage

`default_nettype wire

>>> hdl/sqmm_datapath.sv
// Datapath: operand stores, multiply-accumulate pipeline and output register.
`default_nettype none

module sqmm_datapath (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire sqmm_pkg::dp_cmd_t             cmd,
	output      sqmm_pkg::dp_sts_t             sts,
	input  wire logic [sqmm_pkg::ADDR_W-1:0]   element_index,
	input  wire logic signed [sqmm_pkg::VAL_W-1:0] element_value,
	output      logic                          out_valid,
	input  wire logic                          out_ready,
	output      logic [sqmm_pkg::ADDR_W-1:0]   product_index,
	output      logic signed [sqmm_pkg::ACC_W-1:0] product_value,
	output      logic                          last_entry
);
	import sqmm_pkg::*;

	logic signed [VAL_W-1:0]  left_mem  [STORE_DEPTH];
	logic signed [VAL_W-1:0]  right_mem [STORE_DEPTH];

	logic                     valid_s1;
	logic                     first_s1;
	logic signed [VAL_W-1:0]  a_s1;
	logic signed [VAL_W-1:0]  b_s1;
	logic                     valid_s2;
	logic                     first_s2;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [ACC_W-1:0]  acc_q;
	logic                     out_valid_q;
	logic [ADDR_W-1:0]        index_q;
	logic signed [ACC_W-1:0]  value_q;
	logic                     last_q;

	// Stores: one write port and one registered read port each.
	always_ff @(posedge clk) begin
		if (cmd.wr_a) begin
			left_mem[element_index] <= element_value;
		end
		if (cmd.wr_b) begin
			right_mem[element_index] <= element_value;
		end
		if (cmd.issue) begin
			a_s1 <= left_mem[cmd.a_addr];
			b_s1 <= right_mem[cmd.b_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= cmd.issue;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		first_s1 <= cmd.first;
		first_s2 <= first_s1;
		if (valid_s1) begin
			prod_s2 <= a_s1 * b_s1;
		end
		if (valid_s2) begin
			if (first_s2) begin
				acc_q <= ACC_W'(prod_s2);
			end else begin
				acc_q <= acc_q + ACC_W'(prod_s2);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			index_q <= cmd.index;
			value_q <= acc_q;
			last_q  <= cmd.last;
		end
	end

	assign sts.busy     = valid_s1 | valid_s2;
	assign sts.out_free = !out_valid_q || out_ready;

	assign out_valid     = out_valid_q;
	assign product_index = index_q;
	assign product_value = value_q;
	assign last_entry    = last_q;

endmodule

`default_nettype wire

>>> hdl/sqmm_ctrl.sv
// Controller: sequences loads, the multiply-accumulate walk and result hand-off.
`default_nettype none

module sqmm_ctrl (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output      logic                         in_ready,
	input  wire logic [sqmm_pkg::CMD_W-1:0]   command,
	output      sqmm_pkg::dp_cmd_t            cmd,
	input  wire sqmm_pkg::dp_sts_t            sts
);
	import sqmm_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MAC,
		ST_DRAIN,
		ST_EMIT
	} state_t;

	localparam logic [CNT_W-1:0]  K_LAST     = CNT_W'(MATRIX_SIZE - 1);
	localparam logic [ADDR_W-1:0] COUNT_LAST = ADDR_W'(TOTAL - 1);

	state_t            state_q;
	logic [CNT_W-1:0]  row_q;
	logic [CNT_W-1:0]  col_q;
	logic [CNT_W-1:0]  k_q;
	logic [ADDR_W-1:0] count_q;
	logic              take;
	logic              start;

	assign in_ready = (state_q == ST_IDLE);
	assign take     = in_valid && in_ready;
	assign start    = take && (cmd_code_t'(command) == CMD_START);

	always_comb begin
		cmd        = '0;
		cmd.wr_a   = take && (cmd_code_t'(command) == CMD_LOAD_A);
		cmd.wr_b   = take && (cmd_code_t'(command) == CMD_LOAD_B);
		cmd.issue  = (state_q == ST_MAC);
		cmd.first  = (k_q == '0);
		// Row-major addresses wrap at the store depth for oversized matrices.
		cmd.a_addr = ADDR_W'(int'(row_q) * MATRIX_SIZE + int'(k_q));
		cmd.b_addr = ADDR_W'(int'(k_q) * MATRIX_SIZE + int'(col_q));
		cmd.emit   = (state_q == ST_EMIT) && sts.out_free;
		cmd.index  = count_q;
		cmd.last   = (count_q == COUNT_LAST);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			row_q   <= '0;
			col_q   <= '0;
			k_q     <= '0;
			count_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						row_q   <= '0;
						col_q   <= '0;
						k_q     <= '0;
						count_q <= '0;
						state_q <= ST_MAC;
					end
				end
				ST_MAC: begin
					if (k_q == K_LAST) begin
						k_q     <= '0;
						state_q <= ST_DRAIN;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					if (!sts.busy) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (sts.out_free) begin
						if (count_q == COUNT_LAST) begin
							state_q <= ST_IDLE;
						end else begin
							count_q <= count_q + 1'b1;
							if (col_q == K_LAST) begin
								col_q <= '0;
								row_q <= row_q + 1'b1;
							end else begin
								col_q <= col_q + 1'b1;
							end
							state_q <= ST_MAC;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

>>> hdl/square_matrix_multiply.sv
// Top level of the square matrix multiplier: stream ports, controller and datapath.
//
//  Channel  | Direction | Transfer contents
//  ---------+-----------+-----------------------------------------------------------
//  s_*      | in        | one load of an A or B element, or a start command
//  m_*      | out       | one entry of C = A x B, row-major, tlast on the final entry
//
// Loads are taken one per cycle while idle and follow back to back. A start
// command closes the input while the product is formed: each entry runs a walk
// of MATRIX_SIZE multiply-accumulate steps through the single multiplier, then
// the read/multiply/accumulate pipeline drains and the entry is handed to the
// output register. A stalled m_tready holds the walk at the output register.
// Reset is asynchronous and clears control state only; the operand stores
// come up undefined and must be loaded before they are used.
`default_nettype none

module square_matrix_multiply (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_tvalid,
	output      logic                           s_tready,
	// Fields from bit 0: command[1:0], element_index[7:2], element_value[23:8].
	input  wire logic [sqmm_pkg::S_DATA_W-1:0]  s_tdata,
	output      logic                           m_tvalid,
	input  wire logic                           m_tready,
	// Fields from bit 0: product_index[5:0], product_value[40:6], zero pad[47:41].
	output      logic [sqmm_pkg::M_DATA_W-1:0]  m_tdata,
	output      logic                           m_tlast
);
	import sqmm_pkg::*;

	dp_cmd_t                  cmd;
	dp_sts_t                  sts;
	logic [CMD_W-1:0]         command;
	logic [ADDR_W-1:0]        element_index;
	logic signed [VAL_W-1:0]  element_value;
	logic [ADDR_W-1:0]        product_index;
	logic signed [ACC_W-1:0]  product_value;

	// Unpack the input transfer.
	assign command       = s_tdata[CMD_W-1:0];
	assign element_index = s_tdata[CMD_W +: ADDR_W];
	assign element_value = s_tdata[CMD_W + ADDR_W +: VAL_W];

	sqmm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.command  (command),
		.cmd      (cmd),
		.sts      (sts)
	);

	sqmm_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.element_index (element_index),
		.element_value (element_value),
		.out_valid     (m_tvalid),
		.out_ready     (m_tready),
		.product_index (product_index),
		.product_value (product_value),
		.last_entry    (m_tlast)
	);

	// Pack the output transfer, zero filled to whole bytes.
	assign m_tdata = {{(M_DATA_W - ADDR_W - ACC_W){1'b0}}, product_value, product_index};

endmodule

`default_nettype wire

>>> tb/sqmm_product_checker.sv
// Checker for the matrix multiplier: watches both streams, predicts each product entry and compares.
`timescale 1ns / 100ps

module sqmm_product_checker (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	input  wire logic                          s_tready,
	input  wire logic [sqmm_pkg::S_DATA_W-1:0] s_tdata,
	input  wire logic                          m_tvalid,
	input  wire logic                          m_tready,
	input  wire logic [sqmm_pkg::M_DATA_W-1:0] m_tdata,
	input  wire logic                          m_tlast,
	output int                                 mismatches,
	output int                                 entries_due
);
	import sqmm_pkg::*;

	typedef struct {
		logic [ADDR_W-1:0] index;
		logic [ACC_W-1:0]  value;
		logic              last;
	} product_entry_t;

	// Shadow copies of the two operand stores.
	logic signed [VAL_W-1:0] left_shadow  [STORE_DEPTH];
	logic signed [VAL_W-1:0] right_shadow [STORE_DEPTH];
	product_entry_t          product_due [$];
	int                      mismatch_count = 0;

	// Forms C = A x B from the shadow stores and queues its entries in row-major order.
	task automatic form_product();
		product_entry_t entry;
		longint         acc;
		int             count;
		int             a_addr;
		int             b_addr;
		count = 0;
		for (int row = 0; row < MATRIX_SIZE && count < TOTAL; row++) begin
			for (int col = 0; col < MATRIX_SIZE && count < TOTAL; col++) begin
				acc = 0;
				for (int k = 0; k < MATRIX_SIZE; k++) begin
					a_addr = (row * MATRIX_SIZE + k) % STORE_DEPTH;
					b_addr = (k * MATRIX_SIZE + col) % STORE_DEPTH;
					acc += longint'(left_shadow[a_addr]) * longint'(right_shadow[b_addr]);
				end
				entry.index = ADDR_W'((row * MATRIX_SIZE + col) % STORE_DEPTH);
				entry.value = acc[ACC_W-1:0];
				entry.last  = (count + 1 == TOTAL);
				product_due.push_back(entry);
				count++;
			end
		end
	endtask

	always @(posedge clk) begin
		cmd_code_t         command;
		logic [ADDR_W-1:0] element_index;
		logic [VAL_W-1:0]  element_value;
		product_entry_t    want;
		logic [ADDR_W-1:0] got_index;
		logic [ACC_W-1:0]  got_value;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				command       = cmd_code_t'(s_tdata[CMD_W-1:0]);
				element_index = s_tdata[CMD_W +: ADDR_W];
				element_value = s_tdata[CMD_W+ADDR_W +: VAL_W];
				case (command)
					CMD_LOAD_A: left_shadow[element_index]  = element_value;
					CMD_LOAD_B: right_shadow[element_index] = element_value;
					CMD_START:  form_product();
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				got_index = m_tdata[ADDR_W-1:0];
				got_value = m_tdata[ADDR_W +: ACC_W];
				if (product_due.size() == 0) begin
					if (mismatch_count < 10)
						$display("%0t: unexpected product entry index %0d value %0d last %0b",
							$time, got_index, $signed(got_value), m_tlast);
					mismatch_count++;
				end else begin
					want = product_due.pop_front();
					if (got_index !== want.index || got_value !== want.value ||
							m_tlast !== want.last) begin
						if (mismatch_count < 10)
							$display("%0t: entry expected idx %0d val %0d last %0b, got idx %0d val %0d last %0b",
								$time, want.index, $signed(want.value), want.last,
								got_index, $signed(got_value), m_tlast);
						mismatch_count++;
					end
				end
			end
		end
		mismatches  <= mismatch_count;
		entries_due <= product_due.size();
	end

endmodule

>>> tb/tb.sv
// Testbench top for the matrix multiplier: clock, reset, stream stimulus, receiver stalls and verdict.
`timescale 1ns / 100ps

module tb;
	import sqmm_pkg::*;

	// A stretch this long with no transfer on either channel means the block hung.
	// The longest legal quiet stretch is the deliberate receiver hold-off plus one
	// entry's multiply-accumulate walk.
	localparam int HANG_LIMIT    = 4000;
	localparam int HOLD_CYCLES   = 400;
	localparam int ITEM_TARGET   = 310;
	localparam int DRAIN_CYCLES  = 4 * (MATRIX_SIZE + 4);

	logic                clk = 1'b0;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata;
	logic                m_tvalid;
	logic                m_tready;
	logic [M_DATA_W-1:0] m_tdata;
	logic                m_tlast;
	int                  mismatches;
	int                  entries_due;

	// Run statistics for the closing summary.
	int loads_sent    = 0;
	int starts_sent   = 0;
	int noise_sent    = 0;
	int entries_seen  = 0;
	int burst_left    = 0;
	int quiet_cycles  = 0;

	// Receiver state: a stall mode that changes every so often, and a one-time hold-off.
	int unsigned ready_mode   = 0;
	int unsigned mode_cycles  = 0;
	bit          hold_done    = 1'b0;

	always #10 clk = ~clk;

	square_matrix_multiply dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	sqmm_product_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tlast     (m_tlast),
		.mismatches  (mismatches),
		.entries_due (entries_due)
	);

	// Offers one item and waits for its transfer. The sender works in bursts: valid
	// stays high from one item to the next inside a burst, and drops for a random
	// gap once the burst is used up.
	task automatic offer(input cmd_code_t command, input logic [ADDR_W-1:0] index,
			input logic [VAL_W-1:0] value);
		int gap;
		s_tdata  <= {value, index, command};
		s_tvalid <= 1'b1;
		do
			@(posedge clk);
		while (!s_tready);
		case (command)
			CMD_LOAD_A, CMD_LOAD_B: loads_sent++;
			CMD_START:              starts_sent++;
			default:                noise_sent++;
		endcase
		if (burst_left == 0) begin
			gap = $urandom_range(1, 6);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = $urandom_range(1, 20);
		end else begin
			burst_left--;
		end
	endtask

	// Element values lean toward the corners of the 16-bit range.
	function automatic logic [VAL_W-1:0] pick_value();
		case ($urandom_range(0, 7))
			0:       return 16'h8000;
			1:       return 16'h7fff;
			2:       return 16'h0000;
			3:       return 16'hffff;
			default: return VAL_W'($urandom);
		endcase
	endfunction

	// Counts product entries taken by the receiver; the hold-off keys off this.
	always @(posedge clk)
		if (m_tvalid && m_tready)
			entries_seen <= entries_seen + 1;

	// Receiver. Cycles through four stall patterns: always ready, coin flip, mostly
	// stalled, and strict alternation. Once a product is well under way it holds off
	// for a long stretch so the output register fills and the input backs up.
	initial begin
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (!hold_done && entries_seen >= 20) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = 1'b1;
			end else begin
				if (mode_cycles == 0) begin
					ready_mode  = $urandom_range(0, 3);
					mode_cycles = $urandom_range(32, 160);
				end
				mode_cycles--;
				case (ready_mode)
					0:       m_tready <= 1'b1;
					1:       m_tready <= $urandom_range(0, 1);
					2:       m_tready <= ($urandom_range(0, 3) == 0);
					default: m_tready <= ~m_tready;
				endcase
			end
		end
	end

	// Watchdog: ends the run if neither channel moves for too long.
	initial begin
		while (quiet_cycles < HANG_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("timeout: no transfer for %0d cycles", HANG_LIMIT);
		$display("end of test: mismatches");
		$finish;
	end

	initial begin
		int run_len;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		arst_n   <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n   <= 1'b1;
		@(posedge clk);
		burst_left = $urandom_range(1, 20);

		// Both matrices full of the most negative value: every entry reaches the
		// largest positive dot product. This also writes every store address, so no
		// later product can read an entry that was never loaded.
		for (int i = 0; i < STORE_DEPTH; i++)
			offer(CMD_LOAD_A, ADDR_W'(i), 16'h8000);
		for (int i = 0; i < STORE_DEPTH; i++)
			offer(CMD_LOAD_B, ADDR_W'(i), 16'h8000);
		offer(CMD_START, '0, '0);

		// The unused command code must change nothing, and a second start repeats
		// the same product because starts leave the stores alone.
		offer(CMD_NONE, 6'h3f, 16'hffff);
		offer(CMD_START, 6'h3f, 16'hffff);

		// Most negative times most positive gives the smallest possible sum.
		for (int i = 0; i < STORE_DEPTH; i++)
			offer(CMD_LOAD_B, ADDR_W'(i), 16'h7fff);
		offer(CMD_START, '0, '0);

		// Random part: runs of loads at random addresses with random contents, each
		// closed by a start, with the odd unused command mixed in as noise.
		while (loads_sent + starts_sent < ITEM_TARGET) begin
			run_len = $urandom_range(1, 24);
			for (int n = 0; n < run_len; n++) begin
				if ($urandom_range(0, 9) == 0)
					offer(CMD_NONE, ADDR_W'($urandom), VAL_W'($urandom));
				offer($urandom_range(0, 1) ? CMD_LOAD_B : CMD_LOAD_A,
					ADDR_W'($urandom), pick_value());
			end
			offer(CMD_START, ADDR_W'($urandom), VAL_W'($urandom));
		end
		s_tvalid <= 1'b0;

		// Let the checker's count reflect the last start, then drain.
		@(posedge clk);
		while (entries_due != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d element loads, %0d starts and %0d unused commands;",
			loads_sent, starts_sent, noise_sent);
		$display("%0d product entries compared, %0d mismatches.", entries_seen, mismatches);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
